FILE: rtl/tssa_pkg.sv
// Shared types, constants and the arctangent table for the track segment scatter angle block.
// No dependencies; every other file of the block uses this package.
package tssa_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int INDEX_WIDTH_DEF = 16;

  localparam int LEN_W = 26;
  localparam int SEG_W = 23;
  localparam int ANG_W = 17;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [SEG_W-1:0] SEG_LEN_RESET = 23'd3584;
  localparam logic REG_SEG_LEN = 1'b0;

  // Vectoring unit datapath: dot and cross fit in 53 bits, growth needs two more.
  localparam int CORD_W = 56;
  localparam int Z_W = 27;
  localparam logic [4:0] CORDIC_LAST = 5'd22;
  localparam logic signed [CORD_W-1:0] SCALE_LIMIT = 56'sd549755813888;
  localparam logic signed [Z_W-1:0] HALF_PI_Z = 27'sd6433982;
  localparam logic signed [Z_W-1:0] ROUND_HALF = 27'sd128;
  localparam logic signed [Z_W-1:0] ANGLE_LIMIT = 27'sd50266;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQS, S_SQRT, S_ACC, S_PMUL, S_PDEC, S_CORD, S_OUT
  } seq_state_t;

  typedef enum logic [2:0] {
    C_IDLE, C_PRE, C_SCALE, C_ITER, C_FIN
  } cordic_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // atan(2^-i) in units of 1/4096000 rad.
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:  v = 27'sd3216991;
      5'd1:  v = 27'sd1899101;
      5'd2:  v = 27'sd1003433;
      5'd3:  v = 27'sd509358;
      5'd4:  v = 27'sd255667;
      5'd5:  v = 27'sd127958;
      5'd6:  v = 27'sd63995;
      5'd7:  v = 27'sd31999;
      5'd8:  v = 27'sd16000;
      5'd9:  v = 27'sd8000;
      5'd10: v = 27'sd4000;
      5'd11: v = 27'sd2000;
      5'd12: v = 27'sd1000;
      5'd13: v = 27'sd500;
      5'd14: v = 27'sd250;
      5'd15: v = 27'sd125;
      5'd16: v = 27'sd62;
      5'd17: v = 27'sd31;
      5'd18: v = 27'sd16;
      5'd19: v = 27'sd8;
      5'd20: v = 27'sd4;
      5'd21: v = 27'sd2;
      5'd22: v = 27'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/tssa_if.sv
// Valid/ready channel interfaces for points in and segment words out.
// Depends on tssa_pkg for default widths and field widths.
interface tssa_in_if #(parameter int COORD_WIDTH = tssa_pkg::COORD_WIDTH_DEF);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] x_pos;
  logic signed [COORD_WIDTH-1:0] y_pos;
  logic signed [COORD_WIDTH-1:0] z_pos;
  logic last_point;
  modport source(output valid, x_pos, y_pos, z_pos, last_point, input ready);
  modport sink(input valid, x_pos, y_pos, z_pos, last_point, output ready);
endinterface

interface tssa_out_if #(parameter int INDEX_WIDTH = tssa_pkg::INDEX_WIDTH_DEF);
  logic valid;
  logic ready;
  logic [tssa_pkg::LEN_W-1:0] seg_length;
  logic [INDEX_WIDTH-1:0] end_index;
  logic signed [tssa_pkg::ANG_W-1:0] xz_angle;
  logic signed [tssa_pkg::ANG_W-1:0] yz_angle;
  logic angle_valid;
  logic degenerate;
  logic last_segment;
  modport source(output valid, seg_length, end_index, xz_angle, yz_angle, angle_valid,
                 degenerate, last_segment, input ready);
  modport sink(input valid, seg_length, end_index, xz_angle, yz_angle, angle_valid,
               degenerate, last_segment, output ready);
endinterface

FILE: rtl/tssa_sqrt.sv
// Bit-serial integer square root, one result bit per cycle, rounded to nearest.
// Depends on tssa_pkg for the unit status struct.
module tssa_sqrt #(
  parameter int RW = 26
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [2*RW-1:0]      radicand,
  output tssa_pkg::unit_stat_t stat,
  output logic [RW:0]          root_out
);

  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] rad_r, rad_nxt;
  logic [RW+1:0]   rem_r, rem_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[RW-1:0], rad_r[2*RW-1 -: 2]};
    trial    = {root_r, 2'b01};
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = rad_r << 2;
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[RW-2:0], 1'b0};
      end
      if (cnt_r == CW'(RW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  // The remainder is radicand minus root squared; above root means round up.
  assign root_out = {1'b0, root_r} + ((rem_r > {2'b00, root_r}) ? (RW+1)'(1) : (RW+1)'(0));
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: rtl/tssa_cordic.sv
// Iterative vectoring CORDIC that returns atan2(y, x) in 1/16 mrad.
// Depends on tssa_pkg for widths, the arctangent table and the state type.
module tssa_cordic (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  input  logic signed [tssa_pkg::CORD_W-1:0]       x_in,
  input  logic signed [tssa_pkg::CORD_W-1:0]       y_in,
  output tssa_pkg::unit_stat_t                     stat,
  output logic signed [tssa_pkg::ANG_W-1:0]        angle
);

  tssa_pkg::cordic_state_t state_r, state_nxt;
  logic signed [tssa_pkg::CORD_W-1:0] x_r, x_nxt, y_r, y_nxt, sx, sy;
  logic signed [tssa_pkg::Z_W-1:0]    z_r, z_nxt, zr;
  logic [4:0]                         i_r, i_nxt;
  logic                               x_small, y_small;

  assign sx = x_r >>> i_r;
  assign sy = y_r >>> i_r;
  assign x_small = (x_r < tssa_pkg::SCALE_LIMIT) && (x_r > -tssa_pkg::SCALE_LIMIT);
  assign y_small = (y_r < tssa_pkg::SCALE_LIMIT) && (y_r > -tssa_pkg::SCALE_LIMIT);

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    i_nxt = i_r;
    unique case (state_r)
      tssa_pkg::C_IDLE: begin
        if (start) begin
          x_nxt = x_in;
          y_nxt = y_in;
          z_nxt = '0;
          state_nxt = tssa_pkg::C_PRE;
        end
      end
      tssa_pkg::C_PRE: begin
        if (x_r == '0 && y_r == '0) begin
          state_nxt = tssa_pkg::C_FIN;
        end else begin
          // Fold the left half plane onto the right by a quarter turn.
          if (x_r < 0) begin
            if (y_r >= 0) begin
              x_nxt = y_r;
              y_nxt = -x_r;
              z_nxt = tssa_pkg::HALF_PI_Z;
            end else begin
              x_nxt = -y_r;
              y_nxt = x_r;
              z_nxt = -tssa_pkg::HALF_PI_Z;
            end
          end
          state_nxt = tssa_pkg::C_SCALE;
        end
      end
      tssa_pkg::C_SCALE: begin
        if (x_small && y_small) begin
          x_nxt = x_r <<< 1;
          y_nxt = y_r <<< 1;
        end else begin
          i_nxt = '0;
          state_nxt = tssa_pkg::C_ITER;
        end
      end
      tssa_pkg::C_ITER: begin
        if (y_r >= 0) begin
          x_nxt = x_r + sy;
          y_nxt = y_r - sx;
          z_nxt = z_r + tssa_pkg::atan_entry(i_r);
        end else begin
          x_nxt = x_r - sy;
          y_nxt = y_r + sx;
          z_nxt = z_r - tssa_pkg::atan_entry(i_r);
        end
        if (i_r == tssa_pkg::CORDIC_LAST) begin
          state_nxt = tssa_pkg::C_FIN;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      tssa_pkg::C_FIN: begin
        state_nxt = tssa_pkg::C_IDLE;
      end
      default: state_nxt = tssa_pkg::C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tssa_pkg::C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
  end

  assign zr = (z_r + tssa_pkg::ROUND_HALF) >>> 8;

  always_comb begin
    if (zr > tssa_pkg::ANGLE_LIMIT) begin
      angle = tssa_pkg::ANG_W'(tssa_pkg::ANGLE_LIMIT);
    end else if (zr < -tssa_pkg::ANGLE_LIMIT) begin
      angle = tssa_pkg::ANG_W'(-tssa_pkg::ANGLE_LIMIT);
    end else begin
      angle = zr[tssa_pkg::ANG_W-1:0];
    end
  end

  assign stat.busy = (state_r != tssa_pkg::C_IDLE);
  assign stat.done = (state_r == tssa_pkg::C_FIN);

endmodule

FILE: rtl/track_segment_scatter_angles.sv
// Top level of the track segment scatter angle block: sequencer, shared multiplier, registers.
// Depends on tssa_pkg, tssa_if, tssa_sqrt and tssa_cordic.
//
//   channel  | direction | handshake          | word
//   in_ch    | in        | valid/ready        | x_pos, y_pos, z_pos, last_point
//   out_ch   | out       | valid/ready        | seg_length, end_index, angles, flags
//   cfg (APB)| in        | psel/penable/pready| segment_length at byte address 0
//
// A point that does not close a segment passes the three squares, the bit-serial square
// root of the step length and the length update.
// A closing point with a previous segment adds, per plane, the dot and cross products and,
// unless the plane is degenerate, one CORDIC pass (prescale doubling plus 23 rotations).
// The input is ready only while the sequencer is idle; a finished word waits in the output
// register, and the sequencer stalls in its last state only if that register is still full.
// Reset is synchronous and active low; no clearing pass is needed.
module track_segment_scatter_angles #(
  parameter int COORD_WIDTH = tssa_pkg::COORD_WIDTH_DEF,
  parameter int INDEX_WIDTH = tssa_pkg::INDEX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tssa_in_if.sink                        in_ch,
  tssa_out_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tssa_pkg::PADDR_W-1:0]   paddr,
  input  logic [tssa_pkg::PDATA_W-1:0]   pwdata,
  output logic [tssa_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  // Differences need one bit more than a coordinate; chords above 26 bits get scaled down.
  localparam int DW    = COORD_WIDTH + 1;
  localparam int PW    = 2 * DW;
  localparam int SUMW  = PW + 2;
  localparam int RW    = DW + 1;
  localparam int SHIFT = (COORD_WIDTH > 25) ? (COORD_WIDTH - 25) : 0;
  localparam int SW    = ((RW + 1) > tssa_pkg::LEN_W ? (RW + 1) : tssa_pkg::LEN_W) + 1;
  localparam logic [INDEX_WIDTH-1:0] IDX_MAX = '1;

  tssa_pkg::seq_state_t state_r, state_nxt;

  // Configuration register.
  logic [tssa_pkg::SEG_W-1:0] seg_len_r;
  logic                       cfg_wr;

  // Trajectory state.
  logic signed [COORD_WIDTH-1:0] xin_r, xin_nxt, yin_r, yin_nxt, zin_r, zin_nxt;
  logic                          last_r, last_nxt;
  logic signed [COORD_WIDTH-1:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic signed [COORD_WIDTH-1:0] prev_z_r, prev_z_nxt;
  logic signed [COORD_WIDTH-1:0] start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic signed [COORD_WIDTH-1:0] start_z_r, start_z_nxt;
  logic signed [DW-1:0]          pdir_x_r, pdir_x_nxt, pdir_y_r, pdir_y_nxt;
  logic signed [DW-1:0]          pdir_z_r, pdir_z_nxt;
  logic signed [DW-1:0]          cdx_r, cdx_nxt, cdy_r, cdy_nxt, cdz_r, cdz_nxt;
  logic [tssa_pkg::LEN_W-1:0]    accum_r, accum_nxt;
  logic [INDEX_WIDTH-1:0]        idx_r, idx_nxt;
  logic                          have_point_r, have_point_nxt, have_dir_r, have_dir_nxt;

  // Sequencer working registers.
  logic [2:0]                    cnt_r, cnt_nxt;
  logic                          plane_r, plane_nxt;
  logic [SUMW-1:0]               sumsq_r, sumsq_nxt;
  logic signed [tssa_pkg::CORD_W-1:0] dot_r, dot_nxt, cross_r, cross_nxt;
  logic signed [tssa_pkg::ANG_W-1:0]  xz_r, xz_nxt, yz_r, yz_nxt;
  logic                          deg_r, deg_nxt;

  // Shared multiplier.
  logic signed [DW-1:0]          mul_a, mul_b;
  logic signed [PW-1:0]          prod_r;
  logic signed [tssa_pkg::CORD_W-1:0] prod_c;

  // Output register.
  logic                          out_valid_r, out_valid_nxt;
  logic [tssa_pkg::LEN_W-1:0]    o_len_r, o_len_nxt;
  logic [INDEX_WIDTH-1:0]        o_idx_r, o_idx_nxt;
  logic signed [tssa_pkg::ANG_W-1:0] o_xz_r, o_xz_nxt, o_yz_r, o_yz_nxt;
  logic                          o_av_r, o_av_nxt, o_deg_r, o_deg_nxt, o_last_r, o_last_nxt;

  // Units.
  logic                          sqrt_start, cord_start;
  tssa_pkg::unit_stat_t          sqrt_stat, cord_stat;
  logic [RW:0]                   step_len;
  logic signed [tssa_pkg::ANG_W-1:0] cord_angle;

  // Combinational helpers.
  logic signed [DW-1:0] dx, dy, dz;
  logic signed [DW-1:0] px, py, pz, qx, qy, qz, a0, a1, b0, b1;
  logic [SW-1:0]        asum;
  logic [tssa_pkg::LEN_W-1:0] accum_sat;
  logic                 closes, plane_deg, out_free;

  // ---------------------------------------------------------------------------
  // APB register port: writes land in the access phase, when psel and penable are both high.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == tssa_pkg::REG_SEG_LEN);
  assign prdata = (paddr[2] == tssa_pkg::REG_SEG_LEN) ? tssa_pkg::PDATA_W'(seg_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_len_r <= tssa_pkg::SEG_LEN_RESET;
    end else if (cfg_wr) begin
      seg_len_r <= pwdata[tssa_pkg::SEG_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath helpers. Step deltas come from the held point and the previous one.
  // Chord operands are scaled so that dot and cross stay within 53 bits.
  // ---------------------------------------------------------------------------
  assign dx = DW'(xin_r) - DW'(prev_x_r);
  assign dy = DW'(yin_r) - DW'(prev_y_r);
  assign dz = DW'(zin_r) - DW'(prev_z_r);

  assign px = pdir_x_r >>> SHIFT;
  assign py = pdir_y_r >>> SHIFT;
  assign pz = pdir_z_r >>> SHIFT;
  assign qx = cdx_r >>> SHIFT;
  assign qy = cdy_r >>> SHIFT;
  assign qz = cdz_r >>> SHIFT;

  // The XZ plane pairs x with z, the YZ plane pairs y with z.
  assign a0 = plane_r ? py : px;
  assign a1 = pz;
  assign b0 = plane_r ? qy : qx;
  assign b1 = qz;
  assign plane_deg = (a0 == '0 && a1 == '0) || (b0 == '0 && b1 == '0);

  always_comb begin
    mul_a = a0;
    mul_b = b0;
    if (state_r == tssa_pkg::S_SQ) begin
      case (cnt_r)
        3'd0:    begin mul_a = dx; mul_b = dx; end
        3'd1:    begin mul_a = dy; mul_b = dy; end
        default: begin mul_a = dz; mul_b = dz; end
      endcase
    end else begin
      case (cnt_r)
        3'd0:    begin mul_a = a0; mul_b = b0; end
        3'd1:    begin mul_a = a1; mul_b = b1; end
        3'd2:    begin mul_a = a0; mul_b = b1; end
        default: begin mul_a = a1; mul_b = b0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign prod_c = tssa_pkg::CORD_W'(prod_r);

  // Path length adds up with saturation at the field's full scale.
  assign asum      = SW'(accum_r) + SW'(step_len);
  assign accum_sat = (asum > SW'(tssa_pkg::LEN_MAX)) ? tssa_pkg::LEN_MAX
                                                      : asum[tssa_pkg::LEN_W-1:0];
  assign closes    = (accum_sat >= tssa_pkg::LEN_W'(seg_len_r)) ||
                     (last_r && accum_sat != '0);
  assign out_free  = !out_valid_r || out_ch.ready;

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    xin_nxt        = xin_r;
    yin_nxt        = yin_r;
    zin_nxt        = zin_r;
    last_nxt       = last_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    prev_z_nxt     = prev_z_r;
    start_x_nxt    = start_x_r;
    start_y_nxt    = start_y_r;
    start_z_nxt    = start_z_r;
    pdir_x_nxt     = pdir_x_r;
    pdir_y_nxt     = pdir_y_r;
    pdir_z_nxt     = pdir_z_r;
    cdx_nxt        = cdx_r;
    cdy_nxt        = cdy_r;
    cdz_nxt        = cdz_r;
    accum_nxt      = accum_r;
    idx_nxt        = idx_r;
    have_point_nxt = have_point_r;
    have_dir_nxt   = have_dir_r;
    cnt_nxt        = cnt_r;
    plane_nxt      = plane_r;
    sumsq_nxt      = sumsq_r;
    dot_nxt        = dot_r;
    cross_nxt      = cross_r;
    xz_nxt         = xz_r;
    yz_nxt         = yz_r;
    deg_nxt        = deg_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    o_len_nxt      = o_len_r;
    o_idx_nxt      = o_idx_r;
    o_xz_nxt       = o_xz_r;
    o_yz_nxt       = o_yz_r;
    o_av_nxt       = o_av_r;
    o_deg_nxt      = o_deg_r;
    o_last_nxt     = o_last_r;
    sqrt_start     = 1'b0;
    cord_start     = 1'b0;

    unique case (state_r)
      tssa_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          xin_nxt  = in_ch.x_pos;
          yin_nxt  = in_ch.y_pos;
          zin_nxt  = in_ch.z_pos;
          last_nxt = in_ch.last_point;
          if (!have_point_r) begin
            // First point of a trajectory only opens the first segment.
            prev_x_nxt  = in_ch.x_pos;
            prev_y_nxt  = in_ch.y_pos;
            prev_z_nxt  = in_ch.z_pos;
            start_x_nxt = in_ch.x_pos;
            start_y_nxt = in_ch.y_pos;
            start_z_nxt = in_ch.z_pos;
            have_point_nxt = !in_ch.last_point;
          end else begin
            cnt_nxt   = '0;
            sumsq_nxt = '0;
            state_nxt = tssa_pkg::S_SQ;
          end
        end
      end
      tssa_pkg::S_SQ: begin
        // One square issued per cycle; each product is registered and added in the next cycle.
        if (cnt_r != 3'd0) begin
          sumsq_nxt = sumsq_r + SUMW'(prod_r);
        end
        if (cnt_r == 3'd3) begin
          state_nxt = tssa_pkg::S_SQS;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tssa_pkg::S_SQS: begin
        sqrt_start = 1'b1;
        state_nxt  = tssa_pkg::S_SQRT;
      end
      tssa_pkg::S_SQRT: begin
        if (sqrt_stat.done) begin
          state_nxt = tssa_pkg::S_ACC;
        end
      end
      tssa_pkg::S_ACC: begin
        accum_nxt  = accum_sat;
        idx_nxt    = (idx_r == IDX_MAX) ? idx_r : idx_r + 1'b1;
        prev_x_nxt = xin_r;
        prev_y_nxt = yin_r;
        prev_z_nxt = zin_r;
        if (closes) begin
          cdx_nxt   = DW'(xin_r) - DW'(start_x_r);
          cdy_nxt   = DW'(yin_r) - DW'(start_y_r);
          cdz_nxt   = DW'(zin_r) - DW'(start_z_r);
          xz_nxt    = '0;
          yz_nxt    = '0;
          deg_nxt   = 1'b0;
          cnt_nxt   = '0;
          plane_nxt = 1'b0;
          state_nxt = have_dir_r ? tssa_pkg::S_PMUL : tssa_pkg::S_OUT;
        end else begin
          if (last_r) begin
            have_point_nxt = 1'b0;
            have_dir_nxt   = 1'b0;
            accum_nxt      = '0;
            idx_nxt        = '0;
          end
          state_nxt = tssa_pkg::S_IDLE;
        end
      end
      tssa_pkg::S_PMUL: begin
        // dot = a0*b0 + a1*b1, cross = a0*b1 - a1*b0
        case (cnt_r)
          3'd1:    dot_nxt   = prod_c;
          3'd2:    dot_nxt   = dot_r + prod_c;
          3'd3:    cross_nxt = prod_c;
          3'd4:    cross_nxt = cross_r - prod_c;
          default: ;
        endcase
        if (cnt_r == 3'd4) begin
          state_nxt = tssa_pkg::S_PDEC;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tssa_pkg::S_PDEC: begin
        if (plane_deg) begin
          deg_nxt = 1'b1;
          if (plane_r) begin
            state_nxt = tssa_pkg::S_OUT;
          end else begin
            plane_nxt = 1'b1;
            cnt_nxt   = '0;
            state_nxt = tssa_pkg::S_PMUL;
          end
        end else begin
          cord_start = 1'b1;
          state_nxt  = tssa_pkg::S_CORD;
        end
      end
      tssa_pkg::S_CORD: begin
        if (cord_stat.done) begin
          if (plane_r) begin
            yz_nxt    = cord_angle;
            state_nxt = tssa_pkg::S_OUT;
          end else begin
            xz_nxt    = cord_angle;
            plane_nxt = 1'b1;
            cnt_nxt   = '0;
            state_nxt = tssa_pkg::S_PMUL;
          end
        end
      end
      tssa_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_len_nxt     = accum_r;
          o_idx_nxt     = idx_r;
          o_xz_nxt      = xz_r;
          o_yz_nxt      = yz_r;
          o_av_nxt      = have_dir_r;
          o_deg_nxt     = deg_r;
          o_last_nxt    = last_r;
          // The closed chord becomes the reference for the next segment.
          pdir_x_nxt    = cdx_r;
          pdir_y_nxt    = cdy_r;
          pdir_z_nxt    = cdz_r;
          start_x_nxt   = xin_r;
          start_y_nxt   = yin_r;
          start_z_nxt   = zin_r;
          have_dir_nxt  = 1'b1;
          accum_nxt     = '0;
          if (last_r) begin
            have_point_nxt = 1'b0;
            have_dir_nxt   = 1'b0;
            idx_nxt        = '0;
          end
          state_nxt = tssa_pkg::S_IDLE;
        end
      end
      default: state_nxt = tssa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tssa_pkg::S_IDLE;
      have_point_r <= 1'b0;
      have_dir_r   <= 1'b0;
      accum_r      <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      plane_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      have_point_r <= have_point_nxt;
      have_dir_r   <= have_dir_nxt;
      accum_r      <= accum_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
      plane_r      <= plane_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xin_r     <= xin_nxt;
    yin_r     <= yin_nxt;
    zin_r     <= zin_nxt;
    last_r    <= last_nxt;
    prev_x_r  <= prev_x_nxt;
    prev_y_r  <= prev_y_nxt;
    prev_z_r  <= prev_z_nxt;
    start_x_r <= start_x_nxt;
    start_y_r <= start_y_nxt;
    start_z_r <= start_z_nxt;
    pdir_x_r  <= pdir_x_nxt;
    pdir_y_r  <= pdir_y_nxt;
    pdir_z_r  <= pdir_z_nxt;
    cdx_r     <= cdx_nxt;
    cdy_r     <= cdy_nxt;
    cdz_r     <= cdz_nxt;
    sumsq_r   <= sumsq_nxt;
    dot_r     <= dot_nxt;
    cross_r   <= cross_nxt;
    xz_r      <= xz_nxt;
    yz_r      <= yz_nxt;
    deg_r     <= deg_nxt;
    o_len_r   <= o_len_nxt;
    o_idx_r   <= o_idx_nxt;
    o_xz_r    <= o_xz_nxt;
    o_yz_r    <= o_yz_nxt;
    o_av_r    <= o_av_nxt;
    o_deg_r   <= o_deg_nxt;
    o_last_r  <= o_last_nxt;
  end

  // ---------------------------------------------------------------------------
  // Shared iterative units.
  // ---------------------------------------------------------------------------
  tssa_sqrt #(.RW(RW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sumsq_r),
    .stat     (sqrt_stat),
    .root_out (step_len)
  );

  tssa_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .x_in  (dot_r),
    .y_in  (cross_r),
    .stat  (cord_stat),
    .angle (cord_angle)
  );

  // ---------------------------------------------------------------------------
  // Channel ports.
  // ---------------------------------------------------------------------------
  assign in_ch.ready         = (state_r == tssa_pkg::S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.seg_length   = o_len_r;
  assign out_ch.end_index    = o_idx_r;
  assign out_ch.xz_angle     = o_xz_r;
  assign out_ch.yz_angle     = o_yz_r;
  assign out_ch.angle_valid  = o_av_r;
  assign out_ch.degenerate   = o_deg_r;
  assign out_ch.last_segment = o_last_r;

endmodule

FILE: rtl/tssa_checker.sv
// Port-level checker for the track segment scatter angle block, bound to its top level.
// Depends on tssa_pkg for field widths and the angle limit.
module tssa_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [tssa_pkg::ANG_W-1:0]  xz_angle,
  input logic signed [tssa_pkg::ANG_W-1:0]  yz_angle,
  input logic                               angle_valid,
  input logic                               degenerate
);

  localparam logic signed [tssa_pkg::ANG_W-1:0] LIM = tssa_pkg::ANG_W'(tssa_pkg::ANGLE_LIMIT);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(xz_angle) && $stable(yz_angle) &&
                                $stable(angle_valid) && $stable(degenerate))
    else $error("result word changed while stalled");

  // A new word is handed over only as the sequencer returns to idle.
  a_ready_with_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("word raised while a point is still in work");

  a_first_segment: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !angle_valid |-> xz_angle == '0 && yz_angle == '0 && !degenerate)
    else $error("first segment carries an angle");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> xz_angle <= LIM && xz_angle >= -LIM && yz_angle <= LIM && yz_angle >= -LIM)
    else $error("angle outside its limit");

endmodule

bind track_segment_scatter_angles tssa_checker u_tssa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .xz_angle    (out_ch.xz_angle),
  .yz_angle    (out_ch.yz_angle),
  .angle_valid (out_ch.angle_valid),
  .degenerate  (out_ch.degenerate)
);

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for track_segment_scatter_angles: points in, segment words out.
// Depends on tssa_pkg, the tssa_in_if/tssa_out_if interfaces and the block's RTL.
module testbench;

  localparam longint COORD_MIN = -(64'sd1 << 23);
  localparam longint COORD_MAX = (64'sd1 << 23) - 1;
  localparam int IDX_SAT = 65535;
  localparam int SETTLE_CYCLES = 200;

  // One segment word as it leaves the block.
  typedef struct packed {
    logic [tssa_pkg::LEN_W-1:0] seg_length;
    logic [15:0] end_index;
    logic signed [tssa_pkg::ANG_W-1:0] xz_angle;
    logic signed [tssa_pkg::ANG_W-1:0] yz_angle;
    logic angle_valid;
    logic degenerate;
    logic last_segment;
  } seg_word_t;

  // Tracks the trajectory state, predicts every segment word and checks the block's words.
  class segment_scoreboard;
    logic [tssa_pkg::SEG_W-1:0] seg_len;
    longint px, py, pz, sx, sy, sz, cdx, cdy, cdz;
    longint unsigned path_len;
    bit have_pt, have_chord;
    int unsigned point_idx;
    seg_word_t pending[$];
    int errors;
    longint atan_units[23] = '{3216991, 1899101, 1003433, 509358, 255667, 127958, 63995,
      31999, 16000, 8000, 4000, 2000, 1000, 500, 250, 125, 62, 31, 16, 8, 4, 2, 1};

    function new();
      seg_len = tssa_pkg::SEG_LEN_RESET;
      errors = 0;
      clear_track();
    endfunction

    function void clear_track();
      px = 0; py = 0; pz = 0;
      sx = 0; sy = 0; sz = 0;
      cdx = 0; cdy = 0; cdz = 0;
      path_len = 0;
      have_pt = 0;
      have_chord = 0;
      point_idx = 0;
    endfunction

    function longint unsigned magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // Rounded Euclidean distance; the sum of squares stays below 2^53.
    function longint unsigned step_len(longint dx, longint dy, longint dz);
      longint unsigned sq, r, cand;
      sq = magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy)
         + magnitude(dz) * magnitude(dz);
      r = 0;
      for (int b = 27; b >= 0; b--) begin
        cand = r | (64'd1 << b);
        if (cand * cand <= sq) r = cand;
      end
      if (sq - r * r > r) r++;
      return r;
    endfunction

    // Vectoring arctangent of (x, y) in 1/16 mrad.
    function int vector_angle(longint x, longint y);
      longint z, t, ddx, ddy, r;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; z = tssa_pkg::HALF_PI_Z;
        end else begin
          x = -y; y = t; z = -tssa_pkg::HALF_PI_Z;
        end
      end
      while (magnitude(x) < tssa_pkg::SCALE_LIMIT && magnitude(y) < tssa_pkg::SCALE_LIMIT) begin
        x = x * 2;
        y = y * 2;
      end
      for (int i = 0; i < 23; i++) begin
        ddx = y >>> i;
        ddy = x >>> i;
        if (y >= 0) begin
          x += ddx; y -= ddy; z += atan_units[i];
        end else begin
          x -= ddx; y += ddy; z -= atan_units[i];
        end
      end
      r = (z + 128) >>> 8;
      if (r > tssa_pkg::ANGLE_LIMIT) r = tssa_pkg::ANGLE_LIMIT;
      if (r < -tssa_pkg::ANGLE_LIMIT) r = -tssa_pkg::ANGLE_LIMIT;
      return int'(r);
    endfunction

    function int plane_angle(longint a0, longint a1, longint b0, longint b1, inout bit deg);
      if ((a0 == 0 && a1 == 0) || (b0 == 0 && b1 == 0)) begin
        deg = 1;
        return 0;
      end
      return vector_angle(a0 * b0 + a1 * b1, a0 * b1 - a1 * b0);
    endfunction

    function void note_point(longint x, longint y, longint z, bit last);
      seg_word_t w;
      longint qx, qy, qz;
      bit deg;
      if (!have_pt) begin
        clear_track();
        have_pt = 1;
        px = x; py = y; pz = z;
        sx = x; sy = y; sz = z;
        if (last) clear_track();
        return;
      end
      if (point_idx < IDX_SAT) point_idx++;
      path_len += step_len(x - px, y - py, z - pz);
      if (path_len > tssa_pkg::LEN_MAX) path_len = tssa_pkg::LEN_MAX;
      px = x; py = y; pz = z;
      if (path_len >= seg_len || (last && path_len > 0)) begin
        qx = x - sx; qy = y - sy; qz = z - sz;
        deg = 0;
        w = '0;
        if (have_chord) begin
          w.xz_angle = tssa_pkg::ANG_W'(plane_angle(cdx, cdz, qx, qz, deg));
          w.yz_angle = tssa_pkg::ANG_W'(plane_angle(cdy, cdz, qy, qz, deg));
        end
        w.seg_length = tssa_pkg::LEN_W'(path_len);
        w.end_index = 16'(point_idx);
        w.angle_valid = have_chord;
        w.degenerate = deg;
        w.last_segment = last;
        pending = {pending, w};
        cdx = qx; cdy = qy; cdz = qz;
        have_chord = 1;
        sx = x; sy = y; sz = z;
        path_len = 0;
      end
      if (last) clear_track();
    endfunction

    function void check_word(seg_word_t got);
      seg_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: segment word with none expected, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.seg_length !== want.seg_length || got.end_index !== want.end_index ||
          got.xz_angle !== want.xz_angle || got.yz_angle !== want.yz_angle ||
          got.angle_valid !== want.angle_valid || got.degenerate !== want.degenerate ||
          got.last_segment !== want.last_segment) begin
        $display("%0t: segment word mismatch, expected %p, actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [tssa_pkg::PADDR_W-1:0] paddr;
  logic [tssa_pkg::PDATA_W-1:0] pwdata;
  logic [tssa_pkg::PDATA_W-1:0] prdata;
  logic pready;

  tssa_in_if in_bus ();
  tssa_out_if out_bus ();

  track_segment_scatter_angles dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_bus), .out_ch(out_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  segment_scoreboard sb = new();

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // The receiver stall pattern is redrawn at every falling edge.
  always @(negedge clk) begin
    out_bus.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Words leaving the block are sampled at the rising edge and checked in order.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      sb.check_word('{out_bus.seg_length, out_bus.end_index, out_bus.xz_angle,
                      out_bus.yz_angle, out_bus.angle_valid, out_bus.degenerate,
                      out_bus.last_segment});
    end
  end

  // Generous upper bound on simulated time, far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // Offers one point; valid stays high after acceptance so back-to-back words need no gap.
  task automatic send_point(longint x, longint y, longint z, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid = 0;
      @(negedge clk);
    end
    in_bus.valid = 1;
    in_bus.x_pos = x[23:0];
    in_bus.y_pos = y[23:0];
    in_bus.z_pos = z[23:0];
    in_bus.last_point = last;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_point(x, y, z, last);
    @(negedge clk);
  endtask

  // Holds the sender until every expected word is out, then lets a point that closes
  // nothing finish inside the block.
  task automatic drain();
    in_bus.valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write with a setup and an access phase, issued only while the block is idle.
  task automatic write_seg_len(logic [tssa_pkg::SEG_W-1:0] value);
    drain();
    psel = 1;
    pwrite = 1;
    paddr = tssa_pkg::PADDR_W'(4 * int'(tssa_pkg::REG_SEG_LEN));
    pwdata = tssa_pkg::PDATA_W'(value);
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    sb.seg_len = value;
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  function automatic longint clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic longint rand_coord();
    return longint'($urandom_range(24'hFFFFFF)) - 64'sd8388608;
  endfunction

  // A trajectory of random length. Mostly smooth steps sized against the segment length;
  // about one trajectory in ten is made of jumps anywhere in the coordinate range as noise.
  task automatic send_trajectory();
    int npts;
    longint scale, x, y, z, vx, vy, vz;
    bit wild;
    npts = $urandom_range(1, 20);
    scale = (sb.seg_len / 3) + 8;
    if (scale > (64'sd1 << 22)) scale = 64'sd1 << 22;
    wild = ($urandom_range(9) == 0);
    x = rand_coord();
    y = rand_coord();
    z = rand_coord();
    vx = longint'($urandom_range(32'(2 * scale))) - scale;
    vy = longint'($urandom_range(32'(2 * scale))) - scale;
    vz = longint'($urandom_range(32'(2 * scale))) - scale;
    for (int i = 0; i < npts; i++) begin
      send_point(x, y, z, i == npts - 1);
      if (wild) begin
        x = rand_coord(); y = rand_coord(); z = rand_coord();
      end else begin
        // Bend the direction a little at each point so the angles spread.
        vx += (longint'($urandom_range(32'(scale))) - scale / 2) / 2;
        vy += (longint'($urandom_range(32'(scale))) - scale / 2) / 2;
        vz += (longint'($urandom_range(32'(scale))) - scale / 2) / 2;
        if ($urandom_range(15) == 0) vx = 0;
        x = clamp_coord(x + vx);
        y = clamp_coord(y + vy);
        z = clamp_coord(z + vz);
      end
    end
  endtask

  logic [tssa_pkg::SEG_W-1:0] settings[6];
  int sent;

  initial begin
    rst_n = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_bus.valid = 0;
    in_bus.x_pos = '0; in_bus.y_pos = '0; in_bus.z_pos = '0;
    in_bus.last_point = 0;
    out_bus.ready = 1;
    repeat (11) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed part at the reset length of 3584: a straight run, a reversal that gives +pi,
    // a chord with no XZ projection, and a last point that adds no length.
    send_point(0, 0, 0, 0);
    send_point(0, 0, 3584, 0);
    send_point(0, 0, 7168, 0);
    send_point(0, 0, 3584, 0);
    send_point(0, 3584, 3584, 0);
    send_point(0, 3584, 3584, 1);
    // A trajectory of one point gives nothing.
    send_point(17, -5, 99, 1);
    // Corner to corner jumps give the longest steps; each one closes a segment.
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 0);
    send_point(COORD_MIN, COORD_MIN, COORD_MAX, 0);
    send_point(COORD_MAX, COORD_MIN, COORD_MIN, 0);
    send_point(COORD_MIN, COORD_MAX, COORD_MAX, 1);
    // Short trajectory closed only by its last point.
    send_point(0, 0, 0, 0);
    send_point(100, 50, -20, 0);
    send_point(200, -30, 40, 1);
    // Pause until the block has delivered everything before the length changes.
    write_seg_len('0);
    // Zero length: every point after the first closes, even one that does not move.
    send_point(5, 5, 5, 0);
    send_point(5, 5, 5, 0);
    send_point(9, 2, 7, 0);
    send_point(-3, 8, 1, 1);

    // Random part across several lengths, the extremes among them, with the idle
    // pattern moving from a busy receiver to a busy sender to no idling at all.
    settings = '{tssa_pkg::SEG_LEN_RESET, 23'd1, 23'h7FFFFF, 23'd1000, 23'd0,
                 tssa_pkg::SEG_W'($urandom_range(1, 23'h3FFFF))};
    for (int s = 0; s < 6; s++) begin
      write_seg_len(settings[s]);
      case (s / 2)
        0: begin
          send_idle_pct = 11; recv_stall_pct = 87;
        end
        1: begin
          send_idle_pct = 87; recv_stall_pct = 11;
        end
        default: begin
          send_idle_pct = 0; recv_stall_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < 180) begin
        send_trajectory();
        sent = sent + 10;
      end
    end

    in_bus.valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
